// File: rtl/cfd_pkg.sv
`default_nettype none
package cfd_pkg;

	// Result event codes
	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_OPEN      = 3'd1;
	localparam logic [2:0] EV_APPEND    = 3'd2;
	localparam logic [2:0] EV_DONE      = 3'd3;
	localparam logic [2:0] EV_IGN_END   = 3'd4;
	localparam logic [2:0] EV_NONE_MARK = 3'd5;
	localparam logic [2:0] EV_CUT       = 3'd6;
	localparam logic [2:0] EV_PROTO     = 3'd7;

	// Content kinds
	localparam logic [1:0] KIND_PROC = 2'd0;
	localparam logic [1:0] KIND_LOG  = 2'd1;
	localparam logic [1:0] KIND_CMD  = 2'd2;
	localparam int unsigned NUM_KINDS = 3;

	// Link bytes
	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_CUT       = 8'h0F;
	localparam logic [7:0] CH_ID_PROC   = 8'h11;
	localparam logic [7:0] CH_ID_LOG    = 8'h12;
	localparam logic [7:0] CH_ID_CMD    = 8'h13;
	localparam logic [7:0] CH_NONE_MARK = 8'h15;
	localparam logic [7:0] CH_END       = 8'h17;
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_PRINT_LO  = 8'h20;
	localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

	// Register map (word index)
	localparam logic REG_REFRESH = 1'b0;

	localparam int unsigned WIDX_W = 12;
	localparam int unsigned CLEN_W = 13;

	typedef enum logic [1:0] {
		PH_WAIT = 2'b01,
		PH_DATA = 2'b10
	} phase_t;

	function automatic logic is_text(input logic [7:0] c);
		return (c >= CH_PRINT_LO && c <= CH_PRINT_HI) ||
			c == CH_ESC || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

endpackage
`default_nettype wire

// File: rtl/content_frame_deframer.sv
`default_nettype none
// Content frame deframer: takes one received link byte per beat, with its millisecond
// timestamp, and returns exactly one result beat per input beat: an event code, the current
// content kind, and for appended text the byte and its write index into a downstream
// fragment buffer (for a completed fragment, its length). The parse is a single pass of
// logic into the result register, so a byte is taken every cycle and its result shows in
// the next cycle; in_ready drops only while backpressure holds a result. FRAGMENT_MAX caps
// each of the three fragments. refresh_interval_ms (APB, byte address 0) rate-filters
// process-tree frames; the user writes it only while idle, not enforced by the block.
module content_frame_deframer #(
	parameter int unsigned FRAGMENT_MAX = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [31:0] time_ms,
	input  wire logic        resync,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_res,
	output logic [1:0]       content_kind,
	output logic [7:0]       data_byte,
	output logic [cfd_pkg::WIDX_W-1:0] write_index,
	output logic [cfd_pkg::CLEN_W-1:0] content_length,
	output logic             frame_ignored
);
	import cfd_pkg::*;

	localparam int unsigned LEN_W = $clog2(FRAGMENT_MAX + 1);

	logic [31:0]      refresh_q;
	phase_t           phase_q, phase_d;
	logic [1:0]       kind_q, kind_d;
	logic             ignore_q, ignore_d;
	logic [31:0]      tree_time_q, tree_time_d;
	logic [LEN_W-1:0] frag_len_q [NUM_KINDS];

	logic             frag_clr_all;
	logic             frag_wr;
	logic [LEN_W-1:0] frag_wr_val;
	logic [LEN_W-1:0] cur_len;
	logic [31:0]      cur_len_ext;
	logic [31:0]      elapsed;

	logic [2:0]        ev_d;
	logic [7:0]        dbyte_d;
	logic [WIDX_W-1:0] widx_d;
	logic [CLEN_W-1:0] clen_d;
	logic              in_frame;

	logic in_fire;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_REFRESH);
	assign prdata = (paddr[2] == REG_REFRESH) ? refresh_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= 32'd0;
		end else if (cfg_wr) begin
			refresh_q <= pwdata;
		end
	end

	assign in_ready = !out_valid || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign cur_len     = frag_len_q[kind_q];
	assign cur_len_ext = 32'(cur_len);
	assign elapsed     = time_ms - tree_time_q;

	always_comb begin
		phase_d      = phase_q;
		kind_d       = kind_q;
		ignore_d     = ignore_q;
		tree_time_d  = tree_time_q;
		frag_clr_all = 1'b0;
		frag_wr      = 1'b0;
		frag_wr_val  = '0;
		ev_d         = EV_NONE;
		dbyte_d      = 8'd0;
		widx_d       = '0;
		clen_d       = '0;
		in_frame     = 1'b0;
		if (resync) begin
			frag_clr_all = 1'b1;
			phase_d      = PH_WAIT;
		end else begin
			unique case (phase_q)
				PH_WAIT: begin
					if (rx_byte == CH_NONE_MARK) begin
						ev_d = EV_NONE_MARK;
					end else if (rx_byte == CH_ID_PROC || rx_byte == CH_ID_LOG ||
						rx_byte == CH_ID_CMD) begin
						kind_d   = rx_byte[1:0] - 2'd1;
						ignore_d = 1'b0;
						if (rx_byte == CH_ID_PROC) begin
							if (elapsed > refresh_q) begin
								tree_time_d = time_ms;
							end else begin
								ignore_d = 1'b1;
							end
						end
						phase_d  = PH_DATA;
						in_frame = 1'b1;
						ev_d     = EV_OPEN;
					end
				end
				PH_DATA: begin
					in_frame = 1'b1;
					priority if (rx_byte == CH_CUT) begin
						phase_d = PH_WAIT;
						ev_d    = EV_CUT;
					end else if (rx_byte == CH_END) begin
						if (!ignore_q) begin
							clen_d  = cur_len_ext[CLEN_W-1:0];
							frag_wr = 1'b1;
							ev_d    = EV_DONE;
						end else begin
							ev_d = EV_IGN_END;
						end
						phase_d = PH_WAIT;
					end else if (rx_byte == CH_NUL) begin
						ev_d = EV_NONE;
					end else if (is_text(rx_byte)) begin
						if (!ignore_q && cur_len < LEN_W'(FRAGMENT_MAX)) begin
							widx_d      = cur_len_ext[WIDX_W-1:0];
							dbyte_d     = rx_byte;
							frag_wr     = 1'b1;
							frag_wr_val = cur_len + LEN_W'(1);
							ev_d        = EV_APPEND;
						end
					end else begin
						// discard the fragment of an accepted frame
						frag_wr = !ignore_q;
						phase_d = PH_WAIT;
						ev_d    = EV_PROTO;
					end
				end
				default: begin
					phase_d = PH_WAIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			kind_q      <= KIND_PROC;
			ignore_q    <= 1'b0;
			tree_time_q <= 32'd0;
			for (int i = 0; i < NUM_KINDS; i++) begin
				frag_len_q[i] <= '0;
			end
		end else if (in_fire) begin
			phase_q     <= phase_d;
			kind_q      <= kind_d;
			ignore_q    <= ignore_d;
			tree_time_q <= tree_time_d;
			for (int i = 0; i < NUM_KINDS; i++) begin
				if (frag_clr_all) begin
					frag_len_q[i] <= '0;
				end else if (frag_wr && kind_q == 2'(i)) begin
					frag_len_q[i] <= frag_wr_val;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	// hold the result while the consumer stalls
	always_ff @(posedge clk) begin
		if (in_fire) begin
			event_res      <= ev_d;
			content_kind   <= kind_d;
			data_byte      <= dbyte_d;
			write_index    <= widx_d;
			content_length <= clen_d;
			frame_ignored  <= in_frame && ignore_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/cfd_checker.sv
`default_nettype none
module cfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  event_res,
	input wire logic [1:0]  content_kind,
	input wire logic [7:0]  data_byte,
	input wire logic [11:0] write_index,
	input wire logic [12:0] content_length,
	input wire logic        frame_ignored
);
	import cfd_pkg::*;

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) &&
		$stable(content_length) && $stable(write_index))
	else $error("result beat changed under backpressure");

	// a beat accepted into an empty result register shows next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
	else $error("accepted beat produced no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_APPEND |-> data_byte == 8'd0 && write_index == 12'd0)
	else $error("data fields set without an append");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_DONE |-> content_length == 13'd0)
	else $error("length set without a completed fragment");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> content_kind != 2'd3 &&
		!(frame_ignored && (event_res == EV_NONE_MARK || event_res == EV_APPEND ||
		event_res == EV_DONE)))
	else $error("bad kind or ignored flag on an accepted-frame event");

endmodule

bind content_frame_deframer cfd_checker u_cfd_checker (.*);
`default_nettype wire

// File: tb/sv/content_frame_deframer_tb.sv
`timescale 1ns / 100ps

module content_frame_deframer_tb;
	import cfd_pkg::*;

	localparam int unsigned FRAG_CAP = 4096;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned REPORT_MAX = 10;

	typedef struct packed {
		logic [2:0]        ev;
		logic [1:0]        kind;
		logic [7:0]        dbyte;
		logic [WIDX_W-1:0] widx;
		logic [CLEN_W-1:0] clen;
		logic              skipped;
	} deframe_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        rx_byte = '0;
	logic [31:0]       time_ms = '0;
	logic              resync = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        event_res;
	logic [1:0]        content_kind;
	logic [7:0]        data_byte;
	logic [WIDX_W-1:0] write_index;
	logic [CLEN_W-1:0] content_length;
	logic              frame_ignored;

	content_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.time_ms(time_ms),
		.resync(resync),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.content_kind(content_kind),
		.data_byte(data_byte),
		.write_index(write_index),
		.content_length(content_length),
		.frame_ignored(frame_ignored)
	);

	// Deframer state as the predictor sees it
	logic        in_data = 1'b0;
	logic [1:0]  kind_now = KIND_PROC;
	logic        frame_skipped = 1'b0;
	logic [31:0] last_tree_ms = '0;
	logic [31:0] refresh_ms = '0;
	int unsigned frag_len[NUM_KINDS] = '{default: 0};

	deframe_result_t pending_results[$];
	int unsigned     n_mismatch = 0;
	int unsigned     cycles = 0;
	int unsigned     send_idle_pct = 0;
	int unsigned     stall_pct = 0;
	int unsigned     hold_cycles = 0;
	logic [31:0]     t_now = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic is_payload_char(input logic [7:0] c);
		if (c >= CH_PRINT_LO && c <= CH_PRINT_HI)
			return 1'b1;
		case (c)
			CH_ESC, CH_TAB, CH_CR, CH_LF: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Advance the predicted deframer by one byte and return the result it owes
	function automatic deframe_result_t deframe_byte(input logic [7:0] b, input logic [31:0] t,
			input logic rs);
		deframe_result_t r;
		logic            in_frame;
		logic [1:0]      k;
		logic [31:0]     since_tree;

		r = '0;
		in_frame = 1'b0;
		k = kind_now;
		if (rs) begin
			frag_len = '{default: 0};
			in_data = 1'b0;
		end else if (!in_data) begin
			if (b == CH_NONE_MARK) begin
				r.ev = EV_NONE_MARK;
			end else if (b == CH_ID_PROC || b == CH_ID_LOG || b == CH_ID_CMD) begin
				case (b)
					CH_ID_PROC: kind_now = KIND_PROC;
					CH_ID_LOG:  kind_now = KIND_LOG;
					default:    kind_now = KIND_CMD;
				endcase
				frame_skipped = 1'b0;
				if (kind_now == KIND_PROC) begin
					since_tree = t - last_tree_ms;
					if (since_tree > refresh_ms)
						last_tree_ms = t;
					else
						frame_skipped = 1'b1;
				end
				in_data = 1'b1;
				in_frame = 1'b1;
				r.ev = EV_OPEN;
			end
		end else begin
			in_frame = 1'b1;
			if (b == CH_CUT) begin
				in_data = 1'b0;
				r.ev = EV_CUT;
			end else if (b == CH_END) begin
				if (!frame_skipped) begin
					r.clen = CLEN_W'(frag_len[k]);
					frag_len[k] = 0;
					r.ev = EV_DONE;
				end else begin
					r.ev = EV_IGN_END;
				end
				in_data = 1'b0;
			end else if (b == CH_NUL) begin
				r.ev = EV_NONE;
			end else if (is_payload_char(b)) begin
				if (!frame_skipped && frag_len[k] < FRAG_CAP) begin
					r.widx = WIDX_W'(frag_len[k]);
					r.dbyte = b;
					frag_len[k]++;
					r.ev = EV_APPEND;
				end
			end else begin
				if (!frame_skipped)
					frag_len[k] = 0;
				in_data = 1'b0;
				r.ev = EV_PROTO;
			end
		end
		r.kind = kind_now;
		r.skipped = in_frame && frame_skipped;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		n_mismatch++;
		if (n_mismatch <= REPORT_MAX)
			$display("mismatch in %s: expected 0x%0h, got 0x%0h", what, exp_v, got_v);
	endtask

	always @(posedge clk) begin
		deframe_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat, event", '0, 32'(event_res));
			end else begin
				e = pending_results[0];
				pending_results.delete(0);
				if (e.ev != event_res)
					report_mismatch("event_res", 32'(e.ev), 32'(event_res));
				if (e.kind != content_kind)
					report_mismatch("content_kind", 32'(e.kind), 32'(content_kind));
				if (e.dbyte != data_byte)
					report_mismatch("data_byte", 32'(e.dbyte), 32'(data_byte));
				if (e.widx != write_index)
					report_mismatch("write_index", 32'(e.widx), 32'(write_index));
				if (e.clen != content_length)
					report_mismatch("content_length", 32'(e.clen), 32'(content_length));
				if (e.skipped != frame_ignored)
					report_mismatch("frame_ignored", 32'(e.skipped), 32'(frame_ignored));
			end
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic [31:0] t, input logic rs);
		int unsigned gap;
		gap = 0;
		while (gap < 16 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		time_ms <= t;
		resync <= rs;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(deframe_byte(b, t, rs));
	endtask

	// Drop valid and hold until every result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_refresh(input logic [31:0] v);
		drain_results();
		repeat (2) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_REFRESH, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		refresh_ms = v;
	endtask

	function automatic logic [31:0] next_time();
		if ($urandom_range(99) < 3)
			t_now = $urandom();
		else
			t_now = t_now + $urandom_range(0, 4);
		return t_now;
	endfunction

	function automatic logic [7:0] random_text();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 80)
			return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
		if (r < 85) begin
			case ($urandom_range(3))
				0: return CH_ESC;
				1: return CH_TAB;
				2: return CH_CR;
				default: return CH_LF;
			endcase
		end
		if (r < 90)
			return CH_NUL;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_item(input logic [7:0] b, inout int unsigned count);
		send_byte(b, next_time(), $urandom_range(99) < 2);
		count++;
	endtask

	// Mostly well-formed frames with random content, some noise and broken frames
	task automatic send_random_frame(inout int unsigned count);
		int unsigned r;
		int unsigned len;
		r = $urandom_range(99);
		if (r < 8) begin
			send_item(8'($urandom_range(255)), count);
		end else if (r < 12) begin
			send_item(CH_NONE_MARK, count);
		end else begin
			send_item(CH_ID_PROC + 8'($urandom_range(2)), count);
			len = $urandom_range(0, 12);
			repeat (len) send_item(random_text(), count);
			r = $urandom_range(99);
			if (r < 70)
				send_item(CH_END, count);
			else if (r < 80)
				send_item(CH_CUT, count);
			else if (r < 88)
				send_item($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hFF))
					: 8'h01 + 8'($urandom_range(7)), count);
			else if (r < 94)
				send_byte(8'($urandom_range(255)), next_time(), 1'b1);
		end
	endtask

	task automatic test_directed();
		write_refresh(32'd0);
		send_byte(CH_NONE_MARK, 32'd0, 1'b0);
		send_byte(8'hAB, 32'd0, 1'b0);
		// log frame: text extremes, control chars, NUL, then a bad byte
		send_byte(CH_ID_LOG, 32'd0, 1'b0);
		send_byte(CH_PRINT_LO, 32'd0, 1'b0);
		send_byte(CH_PRINT_HI, 32'd0, 1'b0);
		send_byte(CH_ESC, 32'd0, 1'b0);
		send_byte(CH_TAB, 32'd0, 1'b0);
		send_byte(CH_CR, 32'd0, 1'b0);
		send_byte(CH_LF, 32'd0, 1'b0);
		send_byte(CH_NUL, 32'd0, 1'b0);
		send_byte(8'hFF, 32'd0, 1'b0);
		// cmd fragment continued across a cut
		send_byte(CH_ID_CMD, 32'd1, 1'b0);
		send_byte("x", 32'd1, 1'b0);
		send_byte(CH_CUT, 32'd1, 1'b0);
		send_byte(CH_ID_CMD, 32'd2, 1'b0);
		send_byte("y", 32'd2, 1'b0);
		send_byte(CH_END, 32'd2, 1'b0);
		// accepted proc frame, then one too soon
		send_byte(CH_ID_PROC, 32'd100, 1'b0);
		send_byte("p", 32'd100, 1'b0);
		send_byte(CH_END, 32'd100, 1'b0);
		send_byte(CH_ID_PROC, 32'd100, 1'b0);
		send_byte("q", 32'd100, 1'b0);
		send_byte(CH_END, 32'd100, 1'b0);
		// resync in the middle of a log frame, then an empty fragment
		send_byte(CH_ID_LOG, 32'd101, 1'b0);
		send_byte("z", 32'd101, 1'b0);
		send_byte(CH_ID_LOG, 32'd101, 1'b1);
		send_byte(CH_ID_LOG, 32'd102, 1'b0);
		send_byte(CH_END, 32'd102, 1'b0);
	endtask

	task automatic test_fragment_full();
		send_idle_pct = 0;
		stall_pct = 0;
		send_byte(CH_NUL, t_now, 1'b1);
		send_byte(CH_ID_LOG, t_now, 1'b0);
		repeat (FRAG_CAP + 3)
			send_byte(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)), t_now, 1'b0);
		send_byte(CH_END, t_now, 1'b0);
	endtask

	task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
			input logic [31:0] interval, input int unsigned n_items);
		int unsigned count;
		count = 0;
		write_refresh(interval);
		send_idle_pct = idle;
		stall_pct = stall;
		while (count < n_items)
			send_random_frame(count);
	endtask

	task automatic test_backpressure();
		int unsigned count;
		count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 300;
		while (count < 40)
			send_random_frame(count);
		// pause the sender until the block has emptied, then resume
		drain_results();
		count = 0;
		while (count < 30)
			send_random_frame(count);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fragment_full();
		t_now = 32'hFFFF_FF80;
		test_random_traffic(0, 0, 32'd0, 190);
		test_random_traffic(71, 0, 32'hFFFF_FFFF, 190);
		test_random_traffic(0, 71, $urandom_range(5, 30), 190);
		test_random_traffic(28, 28, $urandom(), 190);
		test_backpressure();
		drain_results();
		repeat (8) @(posedge clk);
		if (n_mismatch == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: content_frame_deframer.f
rtl/cfd_pkg.sv
rtl/content_frame_deframer.sv
rtl/cfd_checker.sv
tb/sv/content_frame_deframer_tb.sv
